FILE: src/front_middle_back_queue_core_macros.svh
// assertion helpers for the queue core
`ifndef FRONT_MIDDLE_BACK_QUEUE_CORE_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_CORE_MACROS_SVH

// checked only outside reset
`define FMBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on each edge that follows an edge on which reset was seen low
`define FMBQ_ASSERT_AFTER_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);

`endif

FILE: src/fmbq_pkg.sv
package fmbq_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } ctl_t;

endpackage

FILE: src/fmbq_cell.sv
module fmbq_cell import fmbq_pkg::*; (
  input  logic                   clk,
  input  logic [IDX_W-1:0]       cell_idx,
  input  ctl_t                   ctl,
  input  logic [VALUE_WIDTH-1:0] load_val,
  input  logic [VALUE_WIDTH-1:0] prev_val,
  input  logic [VALUE_WIDTH-1:0] next_val,
  output logic [VALUE_WIDTH-1:0] val
);

  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] val_nxt;
  logic [CNT_W-1:0]       idx_c;
  logic [CNT_W-1:0]       pos_c;

  assign idx_c = CNT_W'(cell_idx);
  assign pos_c = CNT_W'(ctl.pos);

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (idx_c == pos_c) begin
        val_nxt = load_val;
      end else if (idx_c > pos_c && idx_c <= ctl.cnt) begin
        // make room: take the neighbor below
        val_nxt = prev_val;
      end
    end else if (ctl.rem) begin
      // close the gap: take the neighbor above
      if (idx_c >= pos_c && (idx_c + CNT_W'(1)) < ctl.cnt) begin
        val_nxt = next_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: src/front_middle_back_queue_core.sv
// Ordered queue of up to 64 values held in a row of cells, index 0 at the front.
// Each transaction pushes at the front, middle (index count/2) or back, or pops from
// the front, middle (index (count-1)/2) or back, and yields one result with the
// popped value, a status (ok, empty, full) and the occupancy afterwards. One
// transaction is taken every cycle while in_ready is high: all cells shift or hold
// together at the same clock edge, and the result appears in the output register
// on the following cycle. in_ready is high whenever that register is empty or
// being read in the same cycle. Stored values are undefined after reset; no
// clearing pass is needed since only entries below the occupancy are ever read.
`include "front_middle_back_queue_core_macros.svh"

module front_middle_back_queue_core import fmbq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_popped_value,
  output logic [1:0]  out_status,
  output logic [6:0]  out_occupancy
);

  logic                   out_valid_r;
  logic [31:0]            out_popped_value_r;
  logic [31:0]            out_popped_value_nxt;
  status_t                out_status_r;
  status_t                out_status_nxt;
  logic [6:0]             out_occupancy_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  logic                   accept;
  logic                   is_push;
  logic                   is_pop;
  logic                   full;
  logic                   empty;
  logic                   pop_on_empty;
  logic [CNT_W-1:0]       pos_w;
  ctl_t                   ctl;
  logic [VALUE_WIDTH-1:0] load_val;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign load_val = VALUE_WIDTH'(in_value);

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    pos_w   = '0;
    unique case (in_op)
      OP_PUSH_FRONT: begin
        is_push = 1'b1;
        pos_w   = '0;
      end
      OP_PUSH_MIDDLE: begin
        is_push = 1'b1;
        pos_w   = count_r >> 1;
      end
      OP_PUSH_BACK: begin
        is_push = 1'b1;
        pos_w   = count_r;
      end
      OP_POP_FRONT: begin
        is_pop = 1'b1;
        pos_w  = '0;
      end
      OP_POP_MIDDLE: begin
        is_pop = 1'b1;
        pos_w  = (count_r - CNT_W'(1)) >> 1;
      end
      OP_POP_BACK: begin
        is_pop = 1'b1;
        pos_w  = count_r - CNT_W'(1);
      end
      default: begin
        is_push = 1'b0;
        is_pop  = 1'b0;
      end
    endcase
  end

  assign ctl.ins = accept && is_push && !full;
  assign ctl.rem = accept && is_pop && !empty;
  assign ctl.pos = pos_w[IDX_W-1:0];
  assign ctl.cnt = count_r;

  assign pop_on_empty = accept && is_pop && empty;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_v;
      logic [VALUE_WIDTH-1:0] next_v;
      if (g == 0) begin : g_first
        assign prev_v = '0;
      end else begin : g_mid_lo
        assign prev_v = cell_val[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_v = '0;
      end else begin : g_mid_hi
        assign next_v = cell_val[g+1];
      end
      fmbq_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(g)),
        .ctl      (ctl),
        .load_val (load_val),
        .prev_val (prev_v),
        .next_val (next_v),
        .val      (cell_val[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt            = count_r;
    out_popped_value_nxt = '0;
    out_status_nxt       = ST_OK;
    if (is_push) begin
      if (full) begin
        out_status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_pop) begin
      if (empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        count_nxt            = count_r - CNT_W'(1);
        out_popped_value_nxt = 32'(cell_val[ctl.pos]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_popped_value_r <= out_popped_value_nxt;
      out_status_r       <= out_status_nxt;
      out_occupancy_r    <= 7'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_value_r;
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occupancy_r;

  `FMBQ_ASSERT(a_count_bound, (count_r <= CNT_W'(CAPACITY)), "occupancy above capacity")
  `FMBQ_ASSERT(a_push_grows, ctl.ins |=> (count_r == $past(count_r) + CNT_W'(1)), "push lost")
  `FMBQ_ASSERT(a_pop_empty, pop_on_empty |=> (out_status == ST_EMPTY && empty), "pop on empty")
  `FMBQ_ASSERT_AFTER_RST(a_reset_clean, (!out_valid_r && count_r == '0), "reset left state")

endmodule

FILE: sim/tb_front_middle_back_queue_core.sv
`timescale 1ns / 100ps

module tb_front_middle_back_queue_core;
  import fmbq_pkg::*;

  localparam logic [2:0] OP_UNUSED_6     = 3'd6;
  localparam logic [2:0] OP_UNUSED_7     = 3'd7;
  localparam int         RANDOM_ITEMS    = 450;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         WATCHDOG_LIMIT  = 3000;
  localparam int         DRAIN_CYCLES    = 4;
  localparam int         NUM_ROWS        = 26;

  typedef struct {
    logic [31:0] popped;
    status_t     status;
    logic [6:0]  occupancy;
  } queue_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    int          reps;
    bit          typed;
    logic [31:0] popped;
    status_t     status;
    logic [6:0]  occupancy;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_popped_value;
  logic [1:0]  out_status;
  logic [6:0]  out_occupancy;

  logic [31:0]   mirror_entries[$];
  queue_result_t pending_results[$];
  queue_result_t head_result;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  bit            calm = 1'b0;
  bit            hold_off_req = 1'b0;

  // rows with typed = 1 carry a hand-written result, the rest use the predictor
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{OP_POP_FRONT,   32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY, 7'd0},
    '{OP_POP_MIDDLE,  32'hFFFF_FFFF,  1, 1'b1, 32'h0, ST_EMPTY, 7'd0},
    '{OP_POP_BACK,    32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY, 7'd0},
    '{OP_UNUSED_6,    32'h1234_5678,  1, 1'b1, 32'h0, ST_OK,    7'd0},
    '{OP_PUSH_BACK,   32'hFFFF_FFFF,  1, 1'b1, 32'h0, ST_OK,    7'd1},
    '{OP_PUSH_FRONT,  32'h0000_0000,  1, 1'b1, 32'h0, ST_OK,    7'd2},
    '{OP_PUSH_MIDDLE, 32'h8000_0001,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_PUSH_MIDDLE, 32'h7FFF_FFFE,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_UNUSED_7,    32'hFFFF_FFFF,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_MIDDLE,  32'h0000_0000,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_MIDDLE,  32'hFFFF_FFFF,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_FRONT,   32'h0000_0000,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_BACK,    32'h0000_0000,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_MIDDLE,  32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY, 7'd0},
    '{OP_PUSH_BACK,   32'hA5A5_0000, 60, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_PUSH_MIDDLE, 32'h5A5A_0000,  2, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_PUSH_FRONT,  32'hC3C3_0000,  2, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_PUSH_FRONT,  32'hDEAD_BEEF,  1, 1'b1, 32'h0, ST_FULL,  7'd64},
    '{OP_PUSH_MIDDLE, 32'hFFFF_FFFF,  1, 1'b1, 32'h0, ST_FULL,  7'd64},
    '{OP_PUSH_BACK,   32'h0000_0000,  1, 1'b1, 32'h0, ST_FULL,  7'd64},
    '{OP_UNUSED_6,    32'h0000_0000,  1, 1'b1, 32'h0, ST_OK,    7'd64},
    '{OP_POP_MIDDLE,  32'h0000_0000,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_PUSH_MIDDLE, 32'h0000_0001,  1, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_BACK,    32'h0000_0000, 32, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_FRONT,   32'h0000_0000, 32, 1'b0, 32'h0, ST_OK,    7'd0},
    '{OP_POP_FRONT,   32'hFFFF_FFFF,  1, 1'b1, 32'h0, ST_EMPTY, 7'd0}
  };

  front_middle_back_queue_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic queue_result_t apply_queue_op(logic [2:0] op, logic [31:0] value);
    queue_result_t r;
    int            pos;
    r.popped = '0;
    r.status = ST_OK;
    pos = 0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
        if (mirror_entries.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_MIDDLE) pos = mirror_entries.size() / 2;
          else if (op == OP_PUSH_BACK) pos = mirror_entries.size();
          mirror_entries.insert(pos, value);
        end
      end
      OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
        if (mirror_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_MIDDLE) pos = (mirror_entries.size() - 1) / 2;
          else if (op == OP_POP_BACK) pos = mirror_entries.size() - 1;
          r.popped = mirror_entries[pos];
          mirror_entries.delete(pos);
        end
      end
      default: ;
    endcase
    r.occupancy = 7'(mirror_entries.size());
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(logic [2:0] op, logic [31:0] value, bit typed,
                           queue_result_t typed_result);
    queue_result_t predicted;
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      in_op    <= 3'($urandom);
      in_value <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    predicted = apply_queue_op(op, value);
    pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 24);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_popped_value, 32'h0);
      end else begin
        head_result = pending_results[0];
        pending_results.delete(0);
        if (out_popped_value !== head_result.popped)
          report_mismatch("popped_value", out_popped_value, head_result.popped);
        if (out_status !== head_result.status)
          report_mismatch("status", 32'(out_status), 32'(head_result.status));
        if (out_occupancy !== head_result.occupancy)
          report_mismatch("occupancy", 32'(out_occupancy), 32'(head_result.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("tb_front_middle_back_queue_core failed");
        $finish;
      end
    end
  end

  initial begin
    op_t           push_ops [3];
    op_t           pop_ops [3];
    queue_result_t typed_result;
    logic [2:0]    op;
    logic [31:0]   value;
    int            live_items;
    int            wave_left;
    int            push_bias;
    push_ops = '{OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK};
    pop_ops  = '{OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK};
    live_items = 0;
    wave_left  = 0;
    push_bias  = 50;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_result.popped    = directed_rows[i].popped;
      typed_result.status    = directed_rows[i].status;
      typed_result.occupancy = directed_rows[i].occupancy;
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_item(directed_rows[i].op, directed_rows[i].value + 32'(k),
                  directed_rows[i].typed, typed_result);
    end

    // waves that lean toward pushes or pops so the queue swings between empty and full
    while (live_items < RANDOM_ITEMS) begin
      if (wave_left == 0) begin
        wave_left = $urandom_range(200, 60);
        push_bias = $urandom_range(1) ? 80 : 20;
      end
      wave_left--;
      if (live_items == 100 && !hold_off_req) hold_off_req = 1'b1;
      calm = (live_items >= 250 && live_items < 400);
      if ($urandom_range(99) < 4) begin
        op = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
      end else begin
        op = ($urandom_range(99) < push_bias) ? push_ops[$urandom_range(2)]
                                               : pop_ops[$urandom_range(2)];
        live_items++;
      end
      case ($urandom_range(9))
        0:       value = 32'h0000_0000;
        1:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      send_item(op, value, 1'b0, typed_result);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_front_middle_back_queue_core passed");
    end else begin
      $display("tb_front_middle_back_queue_core failed");
    end
    $finish;
  end

endmodule
